// ===== src/ata_rd_pkg.sv =====
// Shared types, constants and helpers for the ATA PIO LBA28 read sequencer.
package ata_rd_pkg;

   localparam int MAX_CHUNK_SECTORS = 256;
   localparam int WORDS_PER_SECTOR  = 256;
   localparam int SECTOR_BYTES      = 512;
   localparam int SECTOR_SHIFT      = $clog2(SECTOR_BYTES);

   localparam logic [8:0]  MAX_CHUNK  = 9'(MAX_CHUNK_SECTORS);
   localparam logic [8:0]  SECTOR_WDS = 9'(WORDS_PER_SECTOR);
   localparam logic [23:0] MAX_POLL_RESET = 24'd1000000;

   // input commands
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_STATUS = 2'd1;
   localparam logic [1:0] CMD_DATA   = 2'd2;

   // result actions
   localparam logic [2:0] ACT_WRITE  = 3'd0;
   localparam logic [2:0] ACT_STATUS = 3'd1;
   localparam logic [2:0] ACT_DELAY  = 3'd2;
   localparam logic [2:0] ACT_DATA   = 3'd3;
   localparam logic [2:0] ACT_WORD   = 3'd4;
   localparam logic [2:0] ACT_DONE   = 3'd5;

   // task file offsets from the channel base
   localparam logic [2:0] OFS_DATA    = 3'd0;
   localparam logic [2:0] OFS_COUNT   = 3'd2;
   localparam logic [2:0] OFS_LBA_LO  = 3'd3;
   localparam logic [2:0] OFS_LBA_MID = 3'd4;
   localparam logic [2:0] OFS_LBA_HI  = 3'd5;
   localparam logic [2:0] OFS_DRIVE   = 3'd6;
   localparam logic [2:0] OFS_CMDSTAT = 3'd7;

   // completion codes
   localparam logic [2:0] CODE_OK      = 3'd0;
   localparam logic [2:0] CODE_TIMEOUT = 3'd1;
   localparam logic [2:0] CODE_ERR     = 3'd2;
   localparam logic [2:0] CODE_FAULT   = 3'd3;
   localparam logic [2:0] CODE_RANGE   = 3'd4;

   // status bits
   localparam logic [7:0] ST_ERR = 8'h01;
   localparam logic [7:0] ST_DRQ = 8'h08;
   localparam logic [7:0] ST_DF  = 8'h20;
   localparam logic [7:0] ST_BSY = 8'h80;

   localparam logic [7:0] DRIVE_LBA         = 8'hE0;
   localparam logic [7:0] CMD_READ_SECTORS  = 8'h20;
   localparam logic [3:0] SEL_LAST          = 4'd10;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_BSY  = 4'b0010,
      PH_DRQ  = 4'b0100,
      PH_READ = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      K_STATUS = 3'd0,
      K_DONE   = 3'd1,
      K_DATA   = 3'd2,
      K_SELECT = 3'd3,
      K_WORD   = 3'd4
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      job_kind_type tail;
      logic [15:0]  value;
      logic [23:0]  index;
      logic [2:0]   code;
      logic [24:0]  bytes;
      logic [27:0]  lba;
      logic [7:0]   count;
   } job_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  reg_offset;
      logic [15:0] out_value;
      logic [23:0] word_index;
      logic [2:0]  status_code;
      logic [24:0] bytes_read;
   } rsp_type;

   function automatic logic [8:0] chunk_of(logic [15:0] rem);
      return (rem > 16'(MAX_CHUNK)) ? MAX_CHUNK : rem[8:0];
   endfunction

endpackage

// ===== src/ata_rd_front.sv =====
// Front end: takes items, tracks the read state and queues at most one job per item.
module ata_rd_front
   import ata_rd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_start_lba,
   input  logic [15:0] req_sector_total,
   input  logic [7:0]  req_status_byte,
   input  logic [15:0] req_data_word,
   input  logic        csr_valid,
   input  logic [23:0] csr_max_poll,
   output logic        push,
   output job_type     job
);

   phase_type   phase_ff, phase_in;
   logic [31:0] lba_ff, lba_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] saved_ff, saved_in;
   logic [8:0]  chunk_ff, chunk_in;
   logic [8:0]  wls_ff, wls_in;
   logic [23:0] poll_ff, poll_in;
   logic [23:0] pos_ff, pos_in;
   logic [23:0] max_poll_ff;

   logic         is_start;
   logic [8:0]   adv_c;
   logic [31:0]  bc_lba;
   logic [15:0]  bc_rem;
   logic [15:0]  bc_saved;
   logic         use_bc;
   job_kind_type bc_kind;
   logic [2:0]   bc_code;
   logic [24:0]  bc_bytes;
   logic [8:0]   wls_dec;
   logic [8:0]   chunk_dec;

   assign is_start = (req_cmd == CMD_START);
   assign adv_c    = chunk_of(rem_ff);
   assign bc_lba   = is_start ? req_start_lba : lba_ff + 32'(adv_c);
   assign bc_rem   = is_start ? req_sector_total : rem_ff - 16'(adv_c);
   assign bc_saved = is_start ? req_sector_total : saved_ff;
   assign wls_dec  = wls_ff - 9'd1;
   assign chunk_dec = chunk_ff - 9'd1;

   always_comb begin
      bc_code  = CODE_OK;
      bc_bytes = '0;
      if (bc_rem == 16'd0) begin
         bc_kind  = K_DONE;
         bc_bytes = 25'(bc_saved) << SECTOR_SHIFT;
      end else if (|bc_lba[31:28]) begin
         bc_kind = K_DONE;
         bc_code = CODE_RANGE;
      end else begin
         bc_kind = K_STATUS;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      lba_in   = lba_ff;
      rem_in   = rem_ff;
      saved_in = saved_ff;
      chunk_in = chunk_ff;
      wls_in   = wls_ff;
      poll_in  = poll_ff;
      pos_in   = pos_ff;
      push     = 1'b0;
      use_bc   = 1'b0;
      job      = '0;
      if (accept) begin
         case (req_cmd)
            CMD_START: begin
               saved_in = req_sector_total;
               pos_in   = '0;
               wls_in   = '0;
               use_bc   = 1'b1;
            end
            CMD_STATUS: begin
               unique case (phase_ff)
                  PH_BSY: begin
                     push = 1'b1;
                     if ((req_status_byte & ST_BSY) != 8'h00) begin
                        if (poll_ff >= max_poll_ff) begin
                           job.kind = K_DONE;
                           job.code = CODE_TIMEOUT;
                           phase_in = PH_IDLE;
                        end else begin
                           job.kind = K_STATUS;
                           poll_in  = poll_ff + 24'd1;
                        end
                     end else begin
                        job.kind  = K_SELECT;
                        job.lba   = lba_ff[27:0];
                        job.count = chunk_ff[7:0];
                        poll_in   = '0;
                        phase_in  = PH_DRQ;
                     end
                  end
                  PH_DRQ: begin
                     push = 1'b1;
                     if ((req_status_byte & ST_ERR) != 8'h00) begin
                        job.kind = K_DONE;
                        job.code = CODE_ERR;
                        phase_in = PH_IDLE;
                     end else if ((req_status_byte & ST_DF) != 8'h00) begin
                        job.kind = K_DONE;
                        job.code = CODE_FAULT;
                        phase_in = PH_IDLE;
                     end else if ((req_status_byte & ST_DRQ) != 8'h00 &&
                                  (req_status_byte & ST_BSY) == 8'h00) begin
                        job.kind = K_DATA;
                        wls_in   = SECTOR_WDS;
                        phase_in = PH_READ;
                     end else if (poll_ff >= max_poll_ff) begin
                        job.kind = K_DONE;
                        job.code = CODE_TIMEOUT;
                        phase_in = PH_IDLE;
                     end else begin
                        job.kind = K_STATUS;
                        poll_in  = poll_ff + 24'd1;
                     end
                  end
                  default: ;
               endcase
            end
            CMD_DATA: begin
               if (phase_ff == PH_READ) begin
                  push      = 1'b1;
                  job.kind  = K_WORD;
                  job.value = req_data_word;
                  job.index = pos_ff;
                  pos_in    = pos_ff + 24'd1;
                  wls_in    = wls_dec;
                  if (wls_dec != 9'd0) begin
                     job.tail = K_DATA;
                  end else begin
                     chunk_in = chunk_dec;
                     if (chunk_dec != 9'd0) begin
                        job.tail = K_STATUS;
                        poll_in  = '0;
                        phase_in = PH_DRQ;
                     end else begin
                        use_bc = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
         if (use_bc) begin
            push      = 1'b1;
            lba_in    = bc_lba;
            rem_in    = bc_rem;
            job.code  = bc_code;
            job.bytes = bc_bytes;
            if (is_start) begin
               job.kind = bc_kind;
            end else begin
               job.tail = bc_kind;
            end
            if (bc_kind == K_STATUS) begin
               chunk_in = chunk_of(bc_rem);
               poll_in  = '0;
               phase_in = PH_BSY;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         lba_ff      <= '0;
         rem_ff      <= '0;
         saved_ff    <= '0;
         chunk_ff    <= '0;
         wls_ff      <= '0;
         poll_ff     <= '0;
         pos_ff      <= '0;
         max_poll_ff <= MAX_POLL_RESET;
      end else begin
         phase_ff <= phase_in;
         lba_ff   <= lba_in;
         rem_ff   <= rem_in;
         saved_ff <= saved_in;
         chunk_ff <= chunk_in;
         wls_ff   <= wls_in;
         poll_ff  <= poll_in;
         pos_ff   <= pos_in;
         if (csr_valid) begin
            max_poll_ff <= csr_max_poll;
         end
      end
   end

   a_data_ignored: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_DATA && phase_ff != PH_READ) |-> !push)
      else $error("data item outside a sector read produced a job");

   a_words_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_READ) |-> (wls_ff != 9'd0))
      else $error("sector read with no words left");

   a_chunk_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (chunk_ff != 9'd0 && chunk_ff <= MAX_CHUNK))
      else $error("active command with bad sector count");

endmodule

// ===== src/ata_rd_queue.sv =====
// Job queue between the front end and the result sequencer.
module ata_rd_queue
   import ata_rd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    in_ready,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign in_ready   = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && in_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> in_ready)
      else $error("job pushed into a full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

   a_ptr_sync: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

// ===== src/ata_rd_back.sv =====
// Back end: expands each queued job into its sequence of result items.
module ata_rd_back
   import ata_rd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp,
   output logic    rsp_last
);

   logic [3:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_step;
   rsp_type    res;

   function automatic rsp_type single_rsp(job_kind_type k, job_type j);
      rsp_type r;
      r = '0;
      case (k)
         K_STATUS: begin
            r.action     = ACT_STATUS;
            r.reg_offset = OFS_CMDSTAT;
         end
         K_DATA: begin
            r.action     = ACT_DATA;
            r.reg_offset = OFS_DATA;
         end
         K_DONE: begin
            r.action      = ACT_DONE;
            r.status_code = j.code;
            r.bytes_read  = j.bytes;
         end
         default: ;
      endcase
      return r;
   endfunction

   assign load = job_valid && (!valid_ff || rsp_ready);

   always_comb begin
      res        = '0;
      final_step = 1'b1;
      unique case (job.kind)
         K_SELECT: begin
            final_step = (step_ff == SEL_LAST);
            case (step_ff)
               4'd0: begin
                  res.action     = ACT_WRITE;
                  res.reg_offset = OFS_DRIVE;
                  res.out_value  = {8'h00, DRIVE_LBA | {4'h0, job.lba[27:24]}};
               end
               4'd1, 4'd2, 4'd3, 4'd4: begin
                  res.action     = ACT_DELAY;
                  res.reg_offset = OFS_CMDSTAT;
               end
               4'd5: begin
                  res.action     = ACT_WRITE;
                  res.reg_offset = OFS_COUNT;
                  res.out_value  = {8'h00, job.count};
               end
               4'd6: begin
                  res.action     = ACT_WRITE;
                  res.reg_offset = OFS_LBA_LO;
                  res.out_value  = {8'h00, job.lba[7:0]};
               end
               4'd7: begin
                  res.action     = ACT_WRITE;
                  res.reg_offset = OFS_LBA_MID;
                  res.out_value  = {8'h00, job.lba[15:8]};
               end
               4'd8: begin
                  res.action     = ACT_WRITE;
                  res.reg_offset = OFS_LBA_HI;
                  res.out_value  = {8'h00, job.lba[23:16]};
               end
               4'd9: begin
                  res.action     = ACT_WRITE;
                  res.reg_offset = OFS_CMDSTAT;
                  res.out_value  = {8'h00, CMD_READ_SECTORS};
               end
               default: begin
                  res.action     = ACT_STATUS;
                  res.reg_offset = OFS_CMDSTAT;
               end
            endcase
         end
         K_WORD: begin
            final_step = (step_ff == 4'd1);
            if (step_ff == 4'd0) begin
               res.action     = ACT_WORD;
               res.out_value  = job.value;
               res.word_index = job.index;
            end else begin
               res = single_rsp(job.tail, job);
            end
         end
         default: res = single_rsp(job.kind, job);
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         rsp_in   = res;
         last_in  = final_step;
         if (final_step) begin
            step_in = '0;
            pop     = 1'b1;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;
   assign rsp_last  = last_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= SEL_LAST)
      else $error("sequence step out of range");

   a_job_held: assert property (@(posedge clock) disable iff (reset)
      (step_ff != 4'd0) |-> job_valid)
      else $error("job left the queue mid-sequence");

   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      (load && !final_step) |=> (step_ff != 4'd0))
      else $error("sequence step did not advance");

endmodule

// ===== src/ata_pio_lba28_read_sequencer.sv =====
// Top level of the ATA PIO LBA28 read sequencer.
// A start item (cmd 0) begins a read of sector_total sectors at start_lba,
// split into commands of up to 256 sectors; the block answers with bus
// actions (status reads, task file writes, delay reads, data reads), buffer
// words and a final done item carrying a completion code and byte count.
// Status and data replies (cmd 1, 2) drive the sequence on. The front end
// takes one item per cycle whenever the job queue (QUEUE_DEPTH entries) has
// room; each item updates the read state in that cycle and queues at most one
// job. The back end sends one result item per cycle unless rsp_ready stalls
// it; an item yields one result for most replies, two for a data word
// (buffer word plus the next bus action) and eleven for the status reply that
// releases a command's task file writes. Each result's last flag marks the
// end of the results for one input item. Configuration writes are always
// accepted and take effect in the next cycle.
module ata_pio_lba28_read_sequencer
   import ata_rd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_start_lba,
   input  logic [15:0] req_sector_total,
   input  logic [7:0]  req_status_byte,
   input  logic [15:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [2:0]  rsp_reg_offset,
   output logic [15:0] rsp_out_value,
   output logic [23:0] rsp_word_index,
   output logic [2:0]  rsp_status_code,
   output logic [24:0] rsp_bytes_read,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_max_poll
);

   logic    accept;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;
   rsp_type rsp;

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   ata_rd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_cmd          (req_cmd),
      .req_start_lba    (req_start_lba),
      .req_sector_total (req_sector_total),
      .req_status_byte  (req_status_byte),
      .req_data_word    (req_data_word),
      .csr_valid        (csr_valid),
      .csr_max_poll     (csr_max_poll),
      .push             (push),
      .job              (push_job)
   );

   ata_rd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .in_ready   (req_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ata_rd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .rsp_last  (rsp_last)
   );

   assign rsp_action      = rsp.action;
   assign rsp_reg_offset  = rsp.reg_offset;
   assign rsp_out_value   = rsp.out_value;
   assign rsp_word_index  = rsp.word_index;
   assign rsp_status_code = rsp.status_code;
   assign rsp_bytes_read  = rsp.bytes_read;

endmodule
